### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/oele_pkg.sv
package oele_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int TYPE_W  = 3;
  localparam int POS_W   = 5;
  localparam int CODE_W  = 8;
  localparam int TIME_W  = 16;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 4;
  localparam int COUNT_W = 5;

  // Request codes.
  localparam logic [TYPE_W-1:0] RQ_INSERT = 3'd0;
  localparam logic [TYPE_W-1:0] RQ_APPEND = 3'd1;
  localparam logic [TYPE_W-1:0] RQ_DELETE = 3'd2;
  localparam logic [TYPE_W-1:0] RQ_READ   = 3'd3;
  localparam logic [TYPE_W-1:0] RQ_FIND   = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [CODE_W-1:0] pickup;
    logic [CODE_W-1:0] dropoff;
    logic [CODE_W-1:0] item_kind;
    logic [TIME_W-1:0] time_left;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FOUND_W-1:0] found_position;
    logic [CODE_W-1:0]  out_pickup;
    logic [CODE_W-1:0]  out_dropoff;
    logic [CODE_W-1:0]  out_kind;
    logic [TIME_W-1:0]  out_time;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0] pickup;
    logic [CODE_W-1:0] dropoff;
    logic [CODE_W-1:0] kind;
    logic [TIME_W-1:0] time_left;
  } entry_t;

  // What the walk along the chain looks for.
  typedef enum logic [1:0] {
    WK_NONE,
    WK_POS,
    WK_KEY
  } walk_t;

  // How the cells change their contents on the commit cycle.
  typedef enum logic [1:0] {
    ED_NONE,
    ED_INSERT,
    ED_APPEND,
    ED_DELETE
  } edit_t;

  typedef struct packed {
    walk_t             walk;
    edit_t             edit;
    logic [POS_W-1:0]  position;
    entry_t            key;
  } cmd_t;

  typedef struct packed {
    logic   hit;
    entry_t data;
  } carry_t;

endpackage

### rtl/oele_cell.sv
module oele_cell #(
  parameter int DEPTH = oele_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  oele_pkg::cmd_t               cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  oele_pkg::entry_t             left,
  input  oele_pkg::entry_t             right,
  input  oele_pkg::carry_t             carry_in,
  input  logic [$clog2(DEPTH)-1:0]     carry_idx_in,
  output oele_pkg::entry_t             entry,
  output oele_pkg::carry_t             carry_out,
  output logic [$clog2(DEPTH)-1:0]     carry_idx_out
);
  import oele_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [PW-1:0] MY_POS = PW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [PW-1:0] pos_x;
  logic          sel;

  assign pos_x = PW'(cmd.position);

  // A cell only matches a key while it holds a live entry.
  always_comb begin
    unique case (cmd.walk)
      WK_POS:  sel = (MY_POS == pos_x);
      WK_KEY:  sel = (MY_CNT < count) && (entry == cmd.key);
      WK_NONE: sel = 1'b0;
    endcase
  end

  // The first hit travels one cell per cycle toward the tail of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else if (carry_in.hit) begin
      carry_out     <= carry_in;
      carry_idx_out <= carry_idx_in;
    end else if (sel) begin
      carry_out.hit  <= 1'b1;
      carry_out.data <= entry;
      carry_idx_out  <= MY_IDX;
    end else begin
      carry_out.hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.edit)
      ED_INSERT: begin
        if (MY_POS > pos_x) begin
          entry <= left;
        end else if (MY_POS == pos_x) begin
          entry <= cmd.key;
        end
      end
      ED_APPEND: begin
        if (MY_CNT == count) begin
          entry <= cmd.key;
        end
      end
      ED_DELETE: begin
        if (MY_POS >= pos_x) begin
          entry <= right;
        end
      end
      ED_NONE: begin
      end
    endcase
  end

endmodule

### rtl/ordered_entry_list_engine_unit.sv
// Channel   Direction  Word     Handshake
// req       into       req_t    req_valid / req_ready
// rsp       out of     rsp_t    rsp_valid / rsp_ready
//
// Every request waits for the first-hit wave to cross the row of DEPTH cells,
// one cell per cycle, before its response word is formed.
// One request is in flight at a time; a new one is taken while the previous
// response still waits in the output register.
// A stalled response holds the last cycle of the walk until rsp_ready frees
// the output register, and the list changes only on that commit cycle.
// Reset clears the count, the control state and the response valid bit; the
// stored entries are not cleared and are never read before being written.
module ordered_entry_list_engine_unit #(
  parameter int DEPTH = oele_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  oele_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output oele_pkg::rsp_t rsp
);
  import oele_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t              state;
  logic [CW-1:0]       timer;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  req_t                cur;
  logic [STAT_W-1:0]   pre_status;
  walk_t               walk_r;
  edit_t               edit_r;

  logic [STAT_W-1:0]   acc_status;
  walk_t               acc_walk;
  edit_t               acc_edit;
  logic [PW-1:0]       pos_x;
  logic [PW-1:0]       cnt_x;
  logic                accept;
  logic                finish;

  cmd_t                cmd;
  entry_t              entry_arr [DEPTH];
  carry_t              carry_arr [DEPTH+1];
  logic [IW-1:0]       idx_arr   [DEPTH+1];
  carry_t              tail;
  logic [IW-1:0]       tail_idx;
  rsp_t                result;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign finish    = (state == S_WALK) && (timer == '0) && (!rsp_valid || rsp_ready);

  assign pos_x = PW'(req.position);
  assign cnt_x = PW'(count);

  // Checks that only need the count are settled when the request is taken.
  // A full list wins over a bad position for insert; append has no position check.
  always_comb begin
    acc_status = ST_OK;
    acc_walk   = WK_NONE;
    acc_edit   = ED_NONE;
    unique case (req.req_type)
      RQ_INSERT: begin
        if (count == FULL_CNT) begin
          acc_status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_edit = ED_INSERT;
        end
      end
      RQ_APPEND: begin
        if (count == FULL_CNT) begin
          acc_status = ST_FULL;
        end else begin
          acc_edit = ED_APPEND;
        end
      end
      RQ_DELETE: begin
        if (pos_x >= cnt_x) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_walk = WK_POS;
          acc_edit = ED_DELETE;
        end
      end
      RQ_READ: begin
        if (pos_x >= cnt_x) begin
          acc_status = ST_BADPOS;
        end else begin
          acc_walk = WK_POS;
        end
      end
      RQ_FIND: begin
        acc_walk = WK_KEY;
      end
      default: begin
        acc_status = ST_BADPOS;
      end
    endcase
  end

  // The walk runs for the delete, read and find requests that pass their checks; the
  // edit reaches the cells only on the commit cycle, after the entry to return is captured.
  always_comb begin
    cmd.walk          = walk_r;
    cmd.edit          = finish ? edit_r : ED_NONE;
    cmd.position      = cur.position;
    cmd.key.pickup    = cur.pickup;
    cmd.key.dropoff   = cur.dropoff;
    cmd.key.kind      = cur.item_kind;
    cmd.key.time_left = cur.time_left;
  end

  assign carry_arr[0] = '0;
  assign idx_arr[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_n;
    entry_t right_n;

    if (i == 0) begin : g_head
      assign left_n = entry_arr[i];
    end else begin : g_body_l
      assign left_n = entry_arr[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_n = entry_arr[i];
    end else begin : g_body_r
      assign right_n = entry_arr[i+1];
    end

    oele_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .count         (count),
      .left          (left_n),
      .right         (right_n),
      .carry_in      (carry_arr[i]),
      .carry_idx_in  (idx_arr[i]),
      .entry         (entry_arr[i]),
      .carry_out     (carry_arr[i+1]),
      .carry_idx_out (idx_arr[i+1])
    );
  end

  assign tail     = carry_arr[DEPTH];
  assign tail_idx = idx_arr[DEPTH];

  always_comb begin
    unique case (edit_r)
      ED_INSERT, ED_APPEND: count_next = count + 1'b1;
      ED_DELETE:            count_next = count - 1'b1;
      ED_NONE:              count_next = count;
    endcase
  end

  always_comb begin
    result                = '0;
    result.status         = pre_status;
    result.entry_count    = COUNT_W'(count_next);
    if (walk_r == WK_KEY) begin
      if (tail.hit) begin
        result.status         = ST_OK;
        result.found_position = FOUND_W'(tail_idx);
      end else begin
        result.status = ST_NOTFOUND;
      end
    end else if (walk_r == WK_POS) begin
      result.out_pickup  = tail.data.pickup;
      result.out_dropoff = tail.data.dropoff;
      result.out_kind    = tail.data.kind;
      result.out_time    = tail.data.time_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      timer     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
      walk_r    <= WK_NONE;
      edit_r    <= ED_NONE;
    end else begin
      // A commit refills the output register in the same cycle that the
      // previous word leaves it.
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= S_WALK;
            timer      <= FULL_CNT;
            cur        <= req;
            pre_status <= acc_status;
            walk_r     <= acc_walk;
            edit_r     <= acc_edit;
          end
        end
        S_WALK: begin
          if (timer != '0) begin
            timer <= timer - 1'b1;
          end else if (finish) begin
            state <= S_IDLE;
            count <= count_next;
            rsp   <= result;
          end
        end
      endcase
    end
  end

  `ASSERT_SAME(a_count_bound, 1'b1, count <= FULL_CNT, "entry count above depth")
  `ASSERT_NEXT(a_count_hold, !finish, $stable(count), "count moved outside commit")
  `ASSERT_NEXT(a_rsp_after_commit, finish, rsp_valid, "commit without response word")
  `ASSERT_SAME(a_found_only_ok, rsp_valid && (rsp.found_position != '0),
               rsp.status == ST_OK, "found position on failed request")

endmodule
